// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the stable priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic       ACT_INSERT   = 1'b0;
  localparam logic       ACT_POP      = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        action;
    logic [7:0]  priority_req;
    logic [15:0] record_id;
    logic [7:0]  patient_age;
    logic        patient_kind;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_valid;
    logic [7:0]  out_priority;
    logic [15:0] out_record_id;
    logic [7:0]  out_age;
    logic        out_kind;
    logic [4:0]  occupancy;
  } spq_out_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] rec;
    logic [7:0]  age;
    logic        kind;
  } spq_entry_t;

  typedef struct packed {
    logic load;
    logic exec;
  } spq_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } spq_state_t;

endpackage

// ===== hw/rtl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: latches a transaction, then runs one datapath update.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output spq_cmd_t cmd
);

  spq_state_t state_r;
  spq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted cell chain with request and result registers. Each cell compares
// against the request in parallel; an update shifts the chain by one place.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  spq_cmd_t cmd,
  input  spq_in_t  in_data,
  output logic     out_strobe,
  output spq_out_t out_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  spq_in_t           req_r;
  spq_out_t          res_r;
  spq_out_t          res_nxt;
  logic              strobe_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  spq_entry_t        slot_r   [QUEUE_DEPTH];
  spq_entry_t        slot_nxt [QUEUE_DEPTH];
  spq_entry_t        new_entry;
  logic [QUEUE_DEPTH-1:0] ge;
  logic [QUEUE_DEPTH-1:0] ge_prev;
  logic              full;
  logic              empty;
  logic [CNT_W+4:0]  occ_wide;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign new_entry = '{prio: req_r.priority_req, rec: req_r.record_id,
                       age: req_r.patient_age, kind: req_r.patient_kind};

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < count_r) && (slot_r[i].prio >= req_r.priority_req);
    end
  end

  assign ge_prev = {ge[QUEUE_DEPTH-2:0], 1'b1};

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    spq_entry_t from_up;
    spq_entry_t from_down;
    if (g == 0) begin : g_head
      assign from_down = new_entry;
    end else begin : g_body
      assign from_down = slot_r[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign from_up = slot_r[g];
    end else begin : g_inner
      assign from_up = slot_r[g+1];
    end
    always_comb begin
      if (req_r.action == ACT_POP) begin
        slot_nxt[g] = from_up;
      end else if (ge[g]) begin
        slot_nxt[g] = slot_r[g];
      end else if (ge_prev[g]) begin
        slot_nxt[g] = new_entry;
      end else begin
        slot_nxt[g] = from_down;
      end
    end
  end

  always_comb begin
    res_nxt   = '0;
    count_nxt = count_r;
    if (req_r.action == ACT_INSERT) begin
      if (full) begin
        res_nxt.status = STATUS_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        res_nxt.status = STATUS_EMPTY;
      end else begin
        count_nxt             = count_r - CNT_W'(1);
        res_nxt.out_valid     = 1'b1;
        res_nxt.out_priority  = slot_r[0].prio;
        res_nxt.out_record_id = slot_r[0].rec;
        res_nxt.out_age       = slot_r[0].age;
        res_nxt.out_kind      = slot_r[0].kind;
      end
    end
    occ_wide          = {5'd0, count_nxt};
    res_nxt.occupancy = occ_wide[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.exec;
      if (cmd.exec) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
      if (!((req_r.action == ACT_INSERT) && full) &&
          !((req_r.action == ACT_POP) && empty)) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          slot_r[i] <= slot_nxt[i];
        end
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = res_r;

endmodule

// ===== hw/rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue, highest priority at the head, ties served in
// arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. in_data
//   carries the action (insert or pop) and the entry fields.
//   Each transaction produces exactly one result on out_data, marked by
//   out_strobe for one cycle. The receiver cannot stall the block.
// Timing:
//   The request register is loaded at the accepting edge; while busy is
//   high the cell chain updates, and the result register and out_strobe
//   are written as that update ends. busy is high for the one cycle the
//   cell chain updates; a new transaction is taken only after busy falls.
//   The result of one transaction may be shown in the same cycle that the
//   next is accepted.
// Reset:
//   Synchronous active-low reset empties the queue and clears out_strobe.
//   Insert into a full queue reports full; pop on empty reports empty.
// ----------------------------------------------------------------------------
module stable_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  in_data,
  output logic     out_strobe,
  output spq_out_t out_data
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== hw/rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on transaction sequencing and result consistency.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input spq_out_t out_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_strobe && !busy))
    else $error("result strobe missing after busy cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without transaction");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.out_valid) |-> (out_data.status == STATUS_OK))
    else $error("popped entry with error status");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == STATUS_EMPTY) |-> (out_data.occupancy == 5'd0))
    else $error("empty status with nonzero occupancy");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

// ===== verif/tb_stable_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking bench for the stable priority queue. A short table of
// directed transactions covers empty pops, full inserts, priority extremes
// and ties, then random insert/pop traffic with bursts of sender idling and
// one full drain. Results are checked against typed rows or a shadow queue.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 600;
  localparam int CALM_TAIL    = 100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    spq_in_t  stim;
    bit       typed;
    spq_out_t result;
  } table_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spq_in_t  in_data = '0;
  logic     out_strobe;
  spq_out_t out_data;

  spq_entry_t shadow_entries[$];
  spq_out_t   awaited_results[$];
  table_row_t directed_rows[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;

  always #2 clk = ~clk;

  stable_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data)
  );

  function automatic spq_out_t apply_to_shadow_queue(spq_in_t t);
    spq_out_t   r;
    spq_entry_t e;
    int         pos;
    r = '0;
    if (t.action == ACT_INSERT) begin
      if (shadow_entries.size() >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_entries.size() && shadow_entries[pos].prio >= t.priority_req)
          pos++;
        e.prio = t.priority_req;
        e.rec  = t.record_id;
        e.age  = t.patient_age;
        e.kind = t.patient_kind;
        shadow_entries.insert(pos, e);
        r.status = STATUS_OK;
      end
    end else if (shadow_entries.size() == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      e = shadow_entries.pop_front();
      r.status        = STATUS_OK;
      r.out_valid     = 1'b1;
      r.out_priority  = e.prio;
      r.out_record_id = e.rec;
      r.out_age       = e.age;
      r.out_kind      = e.kind;
    end
    r.occupancy = 5'(shadow_entries.size());
    return r;
  endfunction

  function automatic spq_in_t entry_txn(logic act, logic [7:0] p, logic [15:0] rec,
                                        logic [7:0] a, logic k);
    spq_in_t t;
    t.action       = act;
    t.priority_req = p;
    t.record_id    = rec;
    t.patient_age  = a;
    t.patient_kind = k;
    return t;
  endfunction

  function automatic spq_in_t random_txn(int insert_pct);
    logic [7:0] p;
    case ($urandom_range(3))
      0:       p = 8'($urandom_range(0, 3));
      1:       p = $urandom_range(1) ? 8'hFF : 8'h00;
      default: p = 8'($urandom_range(255));
    endcase
    return entry_txn(($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_POP, p,
                     16'($urandom), 8'($urandom), 1'($urandom_range(1)));
  endfunction

  function automatic void add_row(spq_in_t s, bit typed, spq_out_t r);
    table_row_t row;
    row.stim   = s;
    row.typed  = typed;
    row.result = r;
    directed_rows.push_back(row);
  endfunction

  // Drives at the falling edge, returns at the falling edge after acceptance.
  task automatic send_txn(spq_in_t t, bit typed, spq_out_t typed_result);
    spq_out_t predicted;
    start   <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
    predicted = apply_to_shadow_queue(t);
    awaited_results.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  task automatic compare_result(spq_out_t got, spq_out_t expd);
    if (got.status !== expd.status || got.out_valid !== expd.out_valid ||
        got.out_priority !== expd.out_priority || got.out_record_id !== expd.out_record_id ||
        got.out_age !== expd.out_age || got.out_kind !== expd.out_kind ||
        got.occupancy !== expd.occupancy) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $write("%0t bad result: exp st=%0d v=%0b pri=%0d rec=%h age=%0d k=%0b occ=%0d,",
               $realtime, expd.status, expd.out_valid, expd.out_priority,
               expd.out_record_id, expd.out_age, expd.out_kind, expd.occupancy);
        $display(" got st=%0d v=%0b pri=%0d rec=%h age=%0d k=%0b occ=%0d",
                 got.status, got.out_valid, got.out_priority, got.out_record_id,
                 got.out_age, got.out_kind, got.occupancy);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t unexpected result: st=%0d v=%0b occ=%0d", $realtime,
                   out_data.status, out_data.out_valid, out_data.occupancy);
      end else begin
        compare_result(out_data, awaited_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stable_priority_queue: mismatch");
      $finish;
    end
  end

  initial begin
    int insert_pct;
    bit idling_on;
    insert_pct = 50;
    idling_on  = 1'b1;

    add_row(entry_txn(ACT_POP, 8'h00, 16'h0000, 8'h00, 1'b0), 1'b1,
            '{STATUS_EMPTY, 1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 5'd0});
    add_row(entry_txn(ACT_INSERT, 8'h00, 16'h0000, 8'h00, 1'b0), 1'b1,
            '{STATUS_OK, 1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 5'd1});
    add_row(entry_txn(ACT_INSERT, 8'hFF, 16'hFFFF, 8'hFF, 1'b1), 1'b1,
            '{STATUS_OK, 1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 5'd2});
    add_row(entry_txn(ACT_INSERT, 8'h80, 16'h1234, 8'h40, 1'b0), 1'b0, '0);
    add_row(entry_txn(ACT_INSERT, 8'h80, 16'h5678, 8'h41, 1'b1), 1'b0, '0);
    add_row(entry_txn(ACT_INSERT, 8'hFF, 16'h0001, 8'h00, 1'b0), 1'b0, '0);
    add_row(entry_txn(ACT_POP, 8'h00, 16'h0000, 8'h00, 1'b0), 1'b1,
            '{STATUS_OK, 1'b1, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 5'd4});
    add_row(entry_txn(ACT_POP, 8'h00, 16'h0000, 8'h00, 1'b0), 1'b0, '0);
    add_row(entry_txn(ACT_INSERT, 8'h00, 16'hABCD, 8'h7F, 1'b1), 1'b0, '0);
    // fill to capacity with spread priorities
    for (int k = 0; k < 12; k++)
      add_row(entry_txn(ACT_INSERT, 8'(k * 25), 16'(16'h1000 + k), 8'(k), 1'(k)), 1'b0, '0);
    add_row(entry_txn(ACT_INSERT, 8'h55, 16'hBEEF, 8'h33, 1'b1), 1'b1,
            '{STATUS_FULL, 1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 5'd16});
    add_row(entry_txn(ACT_POP, 8'h00, 16'h0000, 8'h00, 1'b0), 1'b0, '0);
    add_row(entry_txn(ACT_POP, 8'h00, 16'h0000, 8'h00, 1'b0), 1'b0, '0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_txn(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].result);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0:       insert_pct = 20;
          1:       insert_pct = 50;
          2:       insert_pct = 65;
          default: insert_pct = 85;
        endcase
        idling_on = ($urandom_range(2) != 0);
      end
      if (n == RANDOM_ITEMS / 2 && awaited_results.size() != 0) begin
        start <= 1'b0;
        while (awaited_results.size() != 0) @(negedge clk);
      end
      send_txn(random_txn(insert_pct), 1'b0, '0);
      if (idling_on && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
    end

    start <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("stable_priority_queue: match");
    end else begin
      $display("stable_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/stable_priority_queue.sv
hw/rtl/spq_checker.sv
verif/tb_stable_priority_queue.sv
